### hdl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared types and constants of the heartbeat membership table.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int ID_W     = 16;
  localparam int PORT_W   = 16;
  localparam int HB_W     = 32;
  localparam int TIME_W   = 32;
  localparam int GP_W     = 8;
  localparam int TO_W     = 16;
  localparam int CNT_W    = 6;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
  localparam logic [1:0] KIND_PRESENCE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STALE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;

  localparam logic [2:0] REG_SELF_ID        = 3'd0;
  localparam logic [2:0] REG_SELF_PORT      = 3'd1;
  localparam logic [2:0] REG_GOSSIP_PERIOD  = 3'd2;
  localparam logic [2:0] REG_FAIL_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_REMOVE_TIMEOUT = 3'd4;

  localparam logic [ID_W-1:0]   RST_SELF_ID        = 16'd1;
  localparam logic [PORT_W-1:0] RST_SELF_PORT      = 16'd0;
  localparam logic [GP_W-1:0]   RST_GOSSIP_PERIOD  = 8'd2;
  localparam logic [TO_W-1:0]   RST_FAIL_TIMEOUT   = 16'd5;
  localparam logic [TO_W-1:0]   RST_REMOVE_TIMEOUT = 16'd20;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   node_id;
    logic [PORT_W-1:0] node_port;
    logic [HB_W-1:0]   heartbeat;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     member_id;
    logic [CNT_W-1:0]    healthy_count;
    logic [CNT_W-1:0]    member_count;
    logic [HB_W-1:0]     own_heartbeat;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   self_id;
    logic [PORT_W-1:0] self_port;
    logic [GP_W-1:0]   gossip_period;
    logic [TO_W-1:0]   fail_timeout;
    logic [TO_W-1:0]   remove_timeout;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic mark;
    logic clear;
    logic flags;
    logic count;
    logic scan_start;
    logic scan_step;
    logic load_remove;
    logic load_final;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_report;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/heartbeat_membership_table_unit.sv
// ----------------------------------------------------------------------------
// heartbeat_membership_table_unit
// Gossip heartbeat membership table with register port, sequencer and table.
//
//   channel  signals                         direction  item
//   req      req_valid / req_ready / req     in         tick or member report
//   rsp      rsp_valid / rsp_ready / rsp     out        status, counts, last
//   apb      psel penable pwrite paddr ...   in/out     configuration registers
//
// a report passes lookup, update, flags, count and final before its result is
// loaded into the output register; an item of unknown kind skips the update.
// a tick passes lookup, mark, clear, flags, count, a removal walk over the slots
// after the own slot, and final; walk and final wait while a loaded result is not taken.
// the next item is taken once the final result is loaded, while it waits.
// synchronous reset leaves only the own entry in the table.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_unit
  import hmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_id        <= RST_SELF_ID;
      cfg.self_port      <= RST_SELF_PORT;
      cfg.gossip_period  <= RST_GOSSIP_PERIOD;
      cfg.fail_timeout   <= RST_FAIL_TIMEOUT;
      cfg.remove_timeout <= RST_REMOVE_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SELF_ID:        cfg.self_id        <= pwdata[ID_W-1:0];
        REG_SELF_PORT:      cfg.self_port      <= pwdata[PORT_W-1:0];
        REG_GOSSIP_PERIOD:  cfg.gossip_period  <= pwdata[GP_W-1:0];
        REG_FAIL_TIMEOUT:   cfg.fail_timeout   <= pwdata[TO_W-1:0];
        REG_REMOVE_TIMEOUT: cfg.remove_timeout <= pwdata[TO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SELF_ID:        prdata = DATA_W'(cfg.self_id);
      REG_SELF_PORT:      prdata = DATA_W'(cfg.self_port);
      REG_GOSSIP_PERIOD:  prdata = DATA_W'(cfg.gossip_period);
      REG_FAIL_TIMEOUT:   prdata = DATA_W'(cfg.fail_timeout);
      REG_REMOVE_TIMEOUT: prdata = DATA_W'(cfg.remove_timeout);
      default:            prdata = '0;
    endcase
  end

  hmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hmt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### hdl/hmt_dp.sv
// ----------------------------------------------------------------------------
// hmt_dp
// Membership table, timers, counters and output register of the table unit.
// ----------------------------------------------------------------------------
module hmt_dp
  import hmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  req_t                req_q;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [ID_W-1:0]     entry_id [TABLE_DEPTH];
  logic [HB_W-1:0]     entry_hb [TABLE_DEPTH];
  logic [TIME_W-1:0]   entry_heard [TABLE_DEPTH];
  logic [TIME_W-1:0]   local_time;
  logic [GP_W-1:0]     gossip_countdown;
  logic [HB_W-1:0]     own_hb;

  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic [STATUS_W-1:0] status_q;
  logic [TABLE_DEPTH-1:0] remove_mask;
  logic [TABLE_DEPTH-1:0] healthy_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic [CNT_W-1:0]    healthy_count;
  logic [CNT_W-1:0]    member_count;
  logic [SLOT_W-1:0]   scan_idx;

  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] remove_vec;
  logic [TABLE_DEPTH-1:0] healthy_now;
  logic                hit_c;
  logic [SLOT_W-1:0]   hit_slot_c;
  logic                free_c;
  logic [SLOT_W-1:0]   free_slot_c;
  logic [ID_W-1:0]     id_at [TABLE_DEPTH];
  logic [TIME_W-1:0]   age [TABLE_DEPTH];

  // slot zero carries the own id straight from the register
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      id_at[i]       = (i == 0) ? cfg.self_id : entry_id[i];
      age[i]         = local_time - entry_heard[i];
      match_vec[i]   = entry_valid[i] && (id_at[i] == req_q.node_id);
      free_vec[i]    = (i != 0) && !entry_valid[i];
      remove_vec[i]  = (i != 0) && entry_valid[i] && (age[i] > TIME_W'(cfg.remove_timeout));
      healthy_now[i] = entry_valid[i] && (age[i] <= TIME_W'(cfg.fail_timeout));
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_c       = 1'b0;
    hit_slot_c  = '0;
    free_c      = 1'b0;
    free_slot_c = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_c      = 1'b1;
        hit_slot_c = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_c      = 1'b1;
        free_slot_c = SLOT_W'(i);
      end
    end
  end

  assign sts.is_tick   = (req_q.kind == KIND_TICK);
  assign sts.is_report = (req_q.kind == KIND_HEARTBEAT) || (req_q.kind == KIND_PRESENCE);
  assign sts.scan_hit  = remove_mask[scan_idx];
  assign sts.scan_last = (scan_idx == SLOT_W'(TABLE_DEPTH - 1));
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.lookup) begin
      hit        <= hit_c;
      hit_slot   <= hit_slot_c;
      free_found <= free_c;
      free_slot  <= free_slot_c;
      status_q   <= (req_q.kind == KIND_TICK) ? ST_TICK_DONE : ST_STALE;
    end
    if (cmd.mark) begin
      remove_mask <= remove_vec;
    end
    if (cmd.flags) begin
      healthy_vec <= healthy_now;
      valid_vec   <= entry_valid;
    end
    if (cmd.count) begin
      healthy_count <= CNT_W'($countones(healthy_vec));
      member_count  <= CNT_W'($countones(valid_vec));
    end
    if (cmd.scan_start) begin
      scan_idx <= SLOT_W'(1);
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + SLOT_W'(1);
    end
    if (cmd.update) begin
      if (hit) begin
        if (req_q.kind == KIND_HEARTBEAT && req_q.heartbeat > entry_hb[hit_slot]) begin
          entry_hb[hit_slot]    <= req_q.heartbeat;
          entry_heard[hit_slot] <= local_time;
          status_q              <= ST_UPDATED;
        end else begin
          status_q <= ST_STALE;
        end
      end else if (free_found) begin
        entry_id[free_slot]    <= req_q.node_id;
        entry_hb[free_slot]    <= (req_q.kind == KIND_HEARTBEAT) ? req_q.heartbeat
                                                                 : local_time;
        entry_heard[free_slot] <= local_time;
        status_q               <= ST_ADDED;
      end else begin
        status_q <= ST_FULL;
      end
    end
    if (cmd.clear) begin
      entry_hb[0]    <= own_hb;
      entry_heard[0] <= local_time + TIME_W'(1);
    end
    if (cmd.load_remove) begin
      rsp.status    <= ST_REMOVED;
      rsp.member_id <= id_at[scan_idx];
      rsp.last      <= 1'b0;
    end else if (cmd.load_final) begin
      rsp.status    <= status_q;
      rsp.member_id <= sts.is_report ? req_q.node_id : '0;
      rsp.last      <= 1'b1;
    end
    if (cmd.load_remove || cmd.load_final) begin
      rsp.healthy_count <= healthy_count;
      rsp.member_count  <= member_count;
      rsp.own_heartbeat <= own_hb;
    end

    if (rst) begin
      entry_valid      <= TABLE_DEPTH'(1);
      entry_hb[0]      <= '0;
      entry_heard[0]   <= '1;
      local_time       <= '1;
      gossip_countdown <= RST_GOSSIP_PERIOD;
      own_hb           <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cmd.update && !hit && free_found) begin
        entry_valid[free_slot] <= 1'b1;
      end
      if (cmd.mark) begin
        if (gossip_countdown != '0) begin
          gossip_countdown <= gossip_countdown - GP_W'(1);
        end else begin
          gossip_countdown <= cfg.gossip_period;
          own_hb           <= own_hb + HB_W'(1);
        end
      end
      if (cmd.clear) begin
        entry_valid <= entry_valid & ~remove_mask;
        local_time  <= local_time + TIME_W'(1);
      end
      if (cmd.load_remove || cmd.load_final) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_remove_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_REMOVED |-> !rsp.last)
    else $error("removal item flagged as last");

  a_counts_sane: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.healthy_count <= rsp.member_count && rsp.member_count != '0)
    else $error("healthy or member count out of range");

  a_own_refresh: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> entry_heard[0] == local_time && entry_valid[0])
    else $error("own entry not refreshed on tick");

endmodule

### hdl/hmt_ctrl.sv
// ----------------------------------------------------------------------------
// hmt_ctrl
// Sequencer of the table unit: lookup, update, tick pass, count and output.
// ----------------------------------------------------------------------------
module hmt_ctrl
  import hmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_MARK,
    S_CLEAR,
    S_FLAGS,
    S_COUNT,
    S_SCAN,
    S_FINAL
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.is_tick) begin
          state_next = S_MARK;
        end else if (sts.is_report) begin
          state_next = S_UPDATE;
        end else begin
          state_next = S_FLAGS;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FLAGS;
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_FLAGS;
      end
      S_FLAGS: begin
        cmd.flags  = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        if (sts.is_tick) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_SCAN: begin
        // removed slots go out in ascending order, others are skipped
        if (!sts.scan_hit || sts.out_free) begin
          cmd.load_remove = sts.scan_hit;
          cmd.scan_step   = 1'b1;
          if (sts.scan_last) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.load_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the heartbeat membership table. A directed table of items
// comes first, then random phases under several register settings. Every
// result item is checked field by field, against the stated result of a typed
// row, else a cycle-free table model. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import hmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  heartbeat_membership_table_unit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model of the table
  logic [ID_W-1:0]   cfg_self_id;
  logic [PORT_W-1:0] cfg_self_port;
  logic [GP_W-1:0]   cfg_gossip;
  logic [TO_W-1:0]   cfg_fail;
  logic [TO_W-1:0]   cfg_remove;
  logic              tbl_valid [DEPTH];
  logic [ID_W-1:0]   tbl_id    [DEPTH];
  logic [PORT_W-1:0] tbl_port  [DEPTH];
  logic [HB_W-1:0]   tbl_hb    [DEPTH];
  logic [TIME_W-1:0] tbl_heard [DEPTH];
  logic [TIME_W-1:0] now_time;
  logic [GP_W-1:0]   gossip_left;
  logic [HB_W-1:0]   own_hb;

  rsp_t pending_rsp[$];
  int   errors = 0;
  bit   quiet = 0;
  bit   want_long_hold = 0;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t result;
  } row_t;
  row_t rows[$];

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic table_reset();
    cfg_self_id   = RST_SELF_ID;
    cfg_self_port = RST_SELF_PORT;
    cfg_gossip    = RST_GOSSIP_PERIOD;
    cfg_fail      = RST_FAIL_TIMEOUT;
    cfg_remove    = RST_REMOVE_TIMEOUT;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 0;
      tbl_id[i]    = '0;
      tbl_port[i]  = '0;
      tbl_hb[i]    = '0;
      tbl_heard[i] = '1;
    end
    tbl_valid[0] = 1;
    tbl_id[0]    = cfg_self_id;
    tbl_port[0]  = cfg_self_port;
    now_time     = '1;
    gossip_left  = cfg_gossip;
    own_hb       = '0;
  endtask

  task automatic predict_step(input req_t it);
    rsp_t out[$];
    rsp_t r;
    int slot;
    int healthy;
    int members;
    logic [STATUS_W-1:0] st;
    logic [TIME_W-1:0] age;
    if (it.kind == KIND_TICK) begin
      if (gossip_left > 0) begin
        gossip_left--;
      end else begin
        gossip_left = cfg_gossip;
        own_hb++;
      end
      for (int i = 1; i < DEPTH; i++) begin
        age = now_time - tbl_heard[i];
        if (tbl_valid[i] && age > cfg_remove) begin
          tbl_valid[i] = 0;
          r = '0;
          r.status = ST_REMOVED;
          r.member_id = tbl_id[i];
          out.push_back(r);
        end
      end
      now_time++;
      tbl_valid[0] = 1;
      tbl_hb[0]    = own_hb;
      tbl_heard[0] = now_time;
      r = '0;
      r.status = ST_TICK_DONE;
      r.last = 1;
      out.push_back(r);
    end else if (it.kind == KIND_HEARTBEAT || it.kind == KIND_PRESENCE) begin
      slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--)
        if (tbl_valid[i] && tbl_id[i] == it.node_id) slot = i;
      if (slot >= 0) begin
        if (it.kind == KIND_HEARTBEAT && it.heartbeat > tbl_hb[slot]) begin
          tbl_hb[slot]    = it.heartbeat;
          tbl_heard[slot] = now_time;
          st = ST_UPDATED;
        end else begin
          st = ST_STALE;
        end
      end else begin
        for (int i = DEPTH - 1; i >= 1; i--)
          if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          st = ST_FULL;
        end else begin
          tbl_valid[slot] = 1;
          tbl_id[slot]    = it.node_id;
          tbl_port[slot]  = it.node_port;
          tbl_hb[slot]    = (it.kind == KIND_HEARTBEAT) ? it.heartbeat : now_time;
          tbl_heard[slot] = now_time;
          st = ST_ADDED;
        end
      end
      r = '0;
      r.status = st;
      r.member_id = it.node_id;
      r.last = 1;
      out.push_back(r);
    end else begin
      r = '0;
      r.status = ST_STALE;
      r.last = 1;
      out.push_back(r);
    end
    healthy = 0;
    members = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) begin
        members++;
        age = now_time - tbl_heard[i];
        if (age <= cfg_fail) healthy++;
      end
    end
    foreach (out[k]) begin
      out[k].healthy_count = CNT_W'(healthy);
      out[k].member_count  = CNT_W'(members);
      out[k].own_heartbeat = own_hb;
      pending_rsp.push_back(out[k]);
    end
  endtask

  // clock, limit
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    case (idx)
      REG_SELF_ID: begin
        cfg_self_id = val[ID_W-1:0];
        tbl_id[0] = cfg_self_id;
      end
      REG_SELF_PORT: begin
        cfg_self_port = val[PORT_W-1:0];
        tbl_port[0] = cfg_self_port;
      end
      REG_GOSSIP_PERIOD:  cfg_gossip = val[GP_W-1:0];
      REG_FAIL_TIMEOUT:   cfg_fail   = val[TO_W-1:0];
      REG_REMOVE_TIMEOUT: cfg_remove = val[TO_W-1:0];
      default: ;
    endcase
  endtask

  // called right at the accepting edge of the last item
  task automatic wait_drained();
    req_valid <= 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input req_t it);
    int gap;
    bit ok;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 19);
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1;
    req       <= it;
    do begin
      @(negedge clk);
      ok = req_ready;
      @(posedge clk);
    end while (!ok);
    predict_step(it);
  endtask

  function automatic req_t make_item(input logic [1:0] k, input logic [ID_W-1:0] id,
                                     input logic [PORT_W-1:0] p, input logic [HB_W-1:0] hb);
    req_t it;
    it.kind = k;
    it.node_id = id;
    it.node_port = p;
    it.heartbeat = hb;
    return it;
  endfunction

  task automatic add_row(input req_t it, input bit typed, input logic [STATUS_W-1:0] st,
                         input logic [ID_W-1:0] mid, input int h, input int m);
    row_t rw;
    rw.item = it;
    rw.typed = typed;
    rw.result = '0;
    rw.result.status = st;
    rw.result.member_id = mid;
    rw.result.healthy_count = CNT_W'(h);
    rw.result.member_count = CNT_W'(m);
    rw.result.own_heartbeat = '0;
    rw.result.last = 1;
    rows.push_back(rw);
  endtask

  function automatic req_t random_item(input int id_pool);
    req_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) it.kind = KIND_TICK;
    else if (pick < 65) it.kind = KIND_HEARTBEAT;
    else if (pick < 92) it.kind = KIND_PRESENCE;
    else it.kind = KIND_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick == 0) it.node_id = ID_W'($urandom);
    else if (pick == 1) it.node_id = cfg_self_id;
    else it.node_id = ID_W'($urandom_range(0, id_pool));
    it.node_port = PORT_W'($urandom);
    it.heartbeat = ($urandom_range(0, 7) == 0) ? HB_W'($urandom)
                                               : HB_W'($urandom_range(0, 60));
    return it;
  endfunction

  // stimulus
  initial begin
    req_t it;
    rst       = 1;
    req_valid = 0;
    req       = '0;
    psel      = 0;
    penable   = 0;
    pwrite    = 0;
    paddr     = '0;
    pwdata    = '0;
    table_reset();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset: own entry only, time all ones
    add_row(make_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, '1), 1, ST_STALE, 16'h0000, 1, 1);
    add_row(make_item(KIND_HEARTBEAT, 16'h0000, 16'hFFFF, '1), 1, ST_ADDED, 16'h0000, 2, 2);
    add_row(make_item(KIND_HEARTBEAT, 16'h0000, 16'h0000, '1), 1, ST_STALE, 16'h0000, 2, 2);
    add_row(make_item(KIND_PRESENCE, 16'hFFFF, 16'h0000, '0), 1, ST_ADDED, 16'hFFFF, 3, 3);
    add_row(make_item(KIND_PRESENCE, 16'hFFFF, 16'h1234, '1), 1, ST_STALE, 16'hFFFF, 3, 3);
    // report naming the own id
    add_row(make_item(KIND_HEARTBEAT, 16'h0001, 16'h0000, 32'd5), 1, ST_UPDATED, 16'h0001,
            3, 3);
    add_row(make_item(KIND_TICK, 16'hFFFF, 16'hFFFF, '1), 1, ST_TICK_DONE, 16'h0000, 3, 3);
    add_row(make_item(KIND_HEARTBEAT, 16'hABCD, 16'h5555, '0), 0, '0, '0, 0, 0);
    add_row(make_item(KIND_HEARTBEAT, 16'hABCD, 16'hAAAA, '0), 0, '0, '0, 0, 0);
    add_row(make_item(KIND_HEARTBEAT, 16'hABCD, 16'hAAAA, 32'd1), 0, '0, '0, 0, 0);
    add_row(make_item(KIND_PRESENCE, 16'h0001, 16'h0000, '0), 0, '0, '0, 0, 0);
    for (int i = 0; i < 6; i++)
      add_row(make_item(KIND_TICK, '0, '0, '0), 0, '0, '0, 0, 0);
    add_row(make_item(KIND_HEARTBEAT, 16'h0000, 16'h0000, 32'h8000_0000), 0, '0, '0, 0, 0);
    add_row(make_item(KIND_UNUSED, '0, '0, '0), 0, '0, '0, 0, 0);
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].typed) pending_rsp[pending_rsp.size() - 1] = rows[i].result;
    end
    wait_drained();

    // zero timeouts and gossip period: every member not heard since the last tick goes on the next tick
    reg_write(REG_SELF_ID, 32'h0000_FFFF);
    reg_write(REG_SELF_PORT, 32'h0000_FFFF);
    reg_write(REG_GOSSIP_PERIOD, 32'h0000_0000);
    reg_write(REG_FAIL_TIMEOUT, 32'h0000_0000);
    reg_write(REG_REMOVE_TIMEOUT, 32'h0000_0000);
    for (int n = 0; n < 40; n++) begin
      if (n == 15) want_long_hold = 1;
      send_item(random_item(40));
    end
    wait_drained();

    // largest settings, fill the table until it is full
    reg_write(REG_SELF_ID, 32'h0000_0007);
    reg_write(REG_SELF_PORT, 32'h0000_0000);
    reg_write(REG_GOSSIP_PERIOD, 32'h0000_00FF);
    reg_write(REG_FAIL_TIMEOUT, 32'h0000_FFFF);
    reg_write(REG_REMOVE_TIMEOUT, 32'h0000_FFFF);
    for (int n = 0; n < 40; n++) begin
      it = random_item(200);
      if (n < 34) begin
        it.kind = KIND_PRESENCE;
        it.node_id = ID_W'(300 + n);
      end
      send_item(it);
    end
    wait_drained();

    // small timeouts with duplicate own id in the table
    reg_write(REG_SELF_ID, 32'h0000_0130);
    reg_write(REG_GOSSIP_PERIOD, 32'h0000_0001);
    reg_write(REG_FAIL_TIMEOUT, 32'h0000_0002);
    reg_write(REG_REMOVE_TIMEOUT, 32'h0000_0004);
    for (int n = 0; n < 40; n++) send_item(random_item(30));
    wait_drained();

    // mid settings, the last part without idling
    reg_write(REG_GOSSIP_PERIOD, 32'h0000_0003);
    reg_write(REG_FAIL_TIMEOUT, 32'h0000_0006);
    reg_write(REG_REMOVE_TIMEOUT, 32'h0000_000C);
    for (int n = 0; n < 50; n++) begin
      if (n == 25) quiet = 1;
      send_item(random_item(50));
    end
    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: checks and receiver stalls
  initial begin
    int hold;
    bit fire;
    rsp_t got;
    rsp_t want;
    hold = 0;
    rsp_ready = 0;
    forever begin
      @(negedge clk);
      fire = rsp_valid && rsp_ready;
      got  = rsp;
      @(posedge clk);
      if (fire) begin
        if (pending_rsp.size() == 0) begin
          flag_mismatch("result item with nothing expected");
        end else begin
          want = pending_rsp.pop_front();
          if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d want %0d", got.status, want.status));
          if (got.member_id !== want.member_id)
            flag_mismatch($sformatf("member_id %h want %h", got.member_id, want.member_id));
          if (got.healthy_count !== want.healthy_count)
            flag_mismatch($sformatf("healthy_count %0d want %0d", got.healthy_count,
                                    want.healthy_count));
          if (got.member_count !== want.member_count)
            flag_mismatch($sformatf("member_count %0d want %0d", got.member_count,
                                    want.member_count));
          if (got.own_heartbeat !== want.own_heartbeat)
            flag_mismatch($sformatf("own_heartbeat %h want %h", got.own_heartbeat,
                                    want.own_heartbeat));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last %b want %b", got.last, want.last));
        end
      end
      if (want_long_hold) begin
        want_long_hold = 0;
        hold = 400;
      end else if (hold == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold > 0) begin
        hold--;
        rsp_ready <= 0;
      end else begin
        rsp_ready <= 1;
      end
    end
  end

endmodule
